[design/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define CGR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, sampled at the rising clock edge.
`define CGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

[design/cgr_pkg.sv]
// Shared constants, register indexes and word types of the cylindrical to
// Cartesian gradient rotation block. No dependencies.
package cgr_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int TRIG_WIDTH      = 16;
   localparam int TRIG_FRAC       = TRIG_WIDTH - 2;
   localparam int INV_WIDTH       = 48;
   localparam int INV_SPLIT       = 24;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 48;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COS_ANGLE  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIN_ANGLE  = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_RADIUS = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ON_AXIS    = CSR_INDEX_WIDTH'(3);

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] disp_vertical;
      logic signed [DATA_WIDTH-1:0] disp_radial;
      logic signed [DATA_WIDTH-1:0] disp_tangential;
      logic signed [DATA_WIDTH-1:0] dz_vertical;
      logic signed [DATA_WIDTH-1:0] dz_radial;
      logic signed [DATA_WIDTH-1:0] dz_tangential;
      logic signed [DATA_WIDTH-1:0] dr_vertical;
      logic signed [DATA_WIDTH-1:0] dr_radial;
      logic signed [DATA_WIDTH-1:0] dr_tangential;
      logic signed [DATA_WIDTH-1:0] dt_vertical;
      logic signed [DATA_WIDTH-1:0] dt_radial;
      logic signed [DATA_WIDTH-1:0] dt_tangential;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] out_disp_z;
      logic signed [DATA_WIDTH-1:0] out_disp_x;
      logic signed [DATA_WIDTH-1:0] out_disp_y;
      logic signed [DATA_WIDTH-1:0] gz_of_z;
      logic signed [DATA_WIDTH-1:0] gz_of_x;
      logic signed [DATA_WIDTH-1:0] gz_of_y;
      logic signed [DATA_WIDTH-1:0] gx_of_z;
      logic signed [DATA_WIDTH-1:0] gx_of_x;
      logic signed [DATA_WIDTH-1:0] gx_of_y;
      logic signed [DATA_WIDTH-1:0] gy_of_z;
      logic signed [DATA_WIDTH-1:0] gy_of_x;
      logic signed [DATA_WIDTH-1:0] gy_of_y;
   } rsp_word_type;

endpackage

[design/cyl_to_cart_gradient_rotation.sv]
// Rotates a displacement sample and its 3x3 gradient from cylindrical to
// Cartesian axes. Input channel req_*, result channel rsp_*, registers csr_*.
//
// Usage: software writes cos/sin of the station azimuth (Q1.14), 1/radius
// (48 fraction bits) and the on-axis flag while no word is in flight; the
// values then hold for the whole stream. Writes to other indexes are dropped.
// Each word on req_* gives exactly one word on rsp_*.
// Pipeline: six register stages (s1 to s5, then the rsp register), passed in
// order. Throughput: one word per cycle while rsp_stall does not hold the pipe.
// Each stage holds at most one multiplier level (32x24 radius partials,
// 32x16 azimuth terms, 33x30 squared-trig terms) or one adder level.
// Stall: each stage loads when it is empty or its successor loads, so
// bubbles close up; req_stall rises only when rsp_stall holds a full pipe.
// A stalled rsp word holds. Words are never dropped or repeated.
// Reset (synchronous): empties the pipe, cos = 1.0, sin = 0, 1/radius = 0,
// on-axis off. req_stall is low in the cycle after reset.
module cyl_to_cart_gradient_rotation
   import cgr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_word_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_word_type               rsp_data,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   localparam int W   = DATA_WIDTH;
   localparam int TW  = TRIG_WIDTH;
   localparam int XW  = W + 1;                    // sum of two data values
   localparam int PW  = W + TW;                   // data x trig
   localparam int LSW = PW + 1;                   // linear sum
   localparam int RHW = W + INV_SPLIT + 1;        // data x half of 1/r
   localparam int RW  = W + INV_WIDTH + 1;        // data x 1/r
   localparam int QW  = 2 * TRIG_FRAC + 2;        // cc, ss, sc in Q1.28
   localparam int QPW = XW + QW;                  // data x squared trig
   localparam int QSW = QPW + 3;                  // up to five terms
   localparam int TRIG_ONE_INT = 1 << TRIG_FRAC;

   localparam logic signed [TW-1:0]  TRIG_POS = TW'(TRIG_ONE_INT);
   localparam logic signed [TW-1:0]  TRIG_NEG = -TRIG_POS;
   localparam logic signed [QW-1:0]  QUAD_ONE = QW'(1) << (2 * TRIG_FRAC);
   localparam logic signed [LSW-1:0] LIN_HALF = LSW'(1) << (TRIG_FRAC - 1);
   localparam logic signed [QSW-1:0] QUAD_HALF = QSW'(1) << (2 * TRIG_FRAC - 1);
   localparam logic signed [RW-1:0]  RAD_HALF = RW'(1) << (INV_WIDTH - 1);
   localparam logic signed [QSW-1:0] SAT_HI = QSW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [QSW-1:0] SAT_LO = ~SAT_HI;

   typedef struct packed {
      logic signed [PW-1:0]  u1_c, u2_s, u1_s, u2_c;
      logic signed [PW-1:0]  s01_c, s02_s, s01_s, s02_c;
      logic signed [PW-1:0]  s10_c, s20_s, s10_s, s20_c;
      logic signed [RHW-1:0] u1_hi, u1_lo, u2_hi, u2_lo;
   } s2_type;

   typedef struct packed {
      logic signed [W-1:0] disp_z, disp_x, disp_y;
      logic signed [W-1:0] gz_z, gz_x, gz_y, gx_z, gy_z;
   } lin_out_type;

   typedef struct packed {
      lin_out_type          lin;
      logic signed [W-1:0]  ur, ut, s11, s12, s21, s22;
      logic signed [XW-1:0] sum_a, sum_b;     // s12 + s21, s11 - s22
   } s3_type;

   typedef struct packed {
      lin_out_type           lin;
      logic signed [QPW-1:0] s11_cc, s22_ss, a_sc, ur_ss, ut_sc;
      logic signed [QPW-1:0] s12_cc, s21_ss, b_sc, ur_sc, ut_ss;
      logic signed [QPW-1:0] s21_cc, s12_ss, ut_cc, s22_cc, s11_ss, ur_cc;
   } s4_type;

   typedef struct packed {
      lin_out_type           lin;
      logic signed [QSW-1:0] xx_a, xx_b, xy_a, xy_b, yx_a, yx_b, yy_a, yy_b;
   } s5_type;

   function automatic logic signed [W-1:0] sat_data(input logic signed [QSW-1:0] v);
      logic signed [W-1:0] res;
      if (v > SAT_HI) begin
         res = SAT_HI[W-1:0];
      end else if (v < SAT_LO) begin
         res = SAT_LO[W-1:0];
      end else begin
         res = v[W-1:0];
      end
      return res;
   endfunction

   // a +/- b, rounded half up by TRIG_FRAC bits, saturated
   function automatic logic signed [W-1:0] lin_result(input logic signed [PW-1:0] a,
                                                      input logic signed [PW-1:0] b,
                                                      input logic subtract);
      logic signed [LSW-1:0] sum;
      logic signed [LSW-1:0] rnd;
      sum = subtract ? (LSW'(a) - LSW'(b)) : (LSW'(a) + LSW'(b));
      rnd = (sum + LIN_HALF) >>> TRIG_FRAC;
      return sat_data(QSW'(rnd));
   endfunction

   function automatic logic signed [W-1:0] quad_result(input logic signed [QSW-1:0] a,
                                                       input logic signed [QSW-1:0] b);
      logic signed [QSW-1:0] rnd;
      rnd = (a + b + QUAD_HALF) >>> (2 * TRIG_FRAC);
      return sat_data(rnd);
   endfunction

   // configuration registers
   logic signed [TW-1:0]    cos_ff, sin_ff;
   logic [INV_WIDTH-1:0]    inv_radius_ff;
   logic                    on_axis_ff;
   // derived trig values
   logic signed [TW-1:0]    trig_c_ff, trig_s_ff, trig_c_in, trig_s_in;
   logic signed [QW-1:0]    trig_cc_ff, trig_ss_ff, trig_sc_ff;
   logic signed [QW-1:0]    trig_cc_in, trig_ss_in, trig_sc_in;
   logic signed [2*TW-1:0]  cc_full, ss_full, sc_full;

   // pipeline
   logic         s1_en, s2_en, s3_en, s4_en, s5_en, out_en;
   logic         s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic         rsp_valid_ff;
   req_word_type s1_word_ff, s2_word_ff;
   s2_type       s2_ff, s2_in;
   s3_type       s3_ff, s3_in;
   s4_type       s4_ff, s4_in;
   s5_type       s5_ff, s5_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   logic signed [RHW-1:0] inv_hi_ext, inv_lo_ext;
   logic signed [RW-1:0]  rad_u1, rad_u2, rad_q1, rad_q2;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff        <= TRIG_POS;
         sin_ff        <= '0;
         inv_radius_ff <= '0;
         on_axis_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COS_ANGLE:  cos_ff        <= csr_wr_data[TW-1:0];
            CSR_SIN_ANGLE:  sin_ff        <= csr_wr_data[TW-1:0];
            CSR_INV_RADIUS: inv_radius_ff <= csr_wr_data[INV_WIDTH-1:0];
            CSR_ON_AXIS:    on_axis_ff    <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      trig_c_in = cos_ff;
      if (cos_ff > TRIG_POS) begin
         trig_c_in = TRIG_POS;
      end else if (cos_ff < TRIG_NEG) begin
         trig_c_in = TRIG_NEG;
      end
      trig_s_in = sin_ff;
      if (sin_ff > TRIG_POS) begin
         trig_s_in = TRIG_POS;
      end else if (sin_ff < TRIG_NEG) begin
         trig_s_in = TRIG_NEG;
      end
      cc_full    = (2*TW)'(trig_c_ff) * (2*TW)'(trig_c_ff);
      ss_full    = (2*TW)'(trig_s_ff) * (2*TW)'(trig_s_ff);
      sc_full    = (2*TW)'(trig_s_ff) * (2*TW)'(trig_c_ff);
      trig_cc_in = cc_full[QW-1:0];
      trig_ss_in = ss_full[QW-1:0];
      trig_sc_in = sc_full[QW-1:0];
   end

   // cc/ss/sc trail the config registers through trig_c/s_ff, then trig_cc/ss/sc_ff;
   // an item reaches the squared-trig multipliers from s3_ff, after s1, s2 and s3.
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_c_ff  <= TRIG_POS;
         trig_s_ff  <= '0;
         trig_cc_ff <= QUAD_ONE;
         trig_ss_ff <= '0;
         trig_sc_ff <= '0;
      end else begin
         trig_c_ff  <= trig_c_in;
         trig_s_ff  <= trig_s_in;
         trig_cc_ff <= trig_cc_in;
         trig_ss_ff <= trig_ss_in;
         trig_sc_ff <= trig_sc_in;
      end
   end

   // ------------------------------------------------------------- handshake
   always_comb begin
      out_en = !rsp_valid_ff || !rsp_stall;
      s5_en  = !s5_valid_ff || out_en;
      s4_en  = !s4_valid_ff || s5_en;
      s3_en  = !s3_valid_ff || s4_en;
      s2_en  = !s2_valid_ff || s3_en;
      s1_en  = !s1_valid_ff || s2_en;
   end

   assign req_stall = !s1_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
         if (s5_en) s5_valid_ff <= s4_valid_ff;
         if (out_en) rsp_valid_ff <= s5_valid_ff;
      end
   end

   // ------------------------------------------- stage 2: first multipliers
   assign inv_hi_ext = RHW'({1'b0, inv_radius_ff[INV_WIDTH-1:INV_SPLIT]});
   assign inv_lo_ext = RHW'({1'b0, inv_radius_ff[INV_SPLIT-1:0]});

   always_comb begin
      s2_in.u1_c  = PW'(s1_word_ff.disp_radial)     * PW'(trig_c_ff);
      s2_in.u2_s  = PW'(s1_word_ff.disp_tangential) * PW'(trig_s_ff);
      s2_in.u1_s  = PW'(s1_word_ff.disp_radial)     * PW'(trig_s_ff);
      s2_in.u2_c  = PW'(s1_word_ff.disp_tangential) * PW'(trig_c_ff);
      s2_in.s01_c = PW'(s1_word_ff.dz_radial)       * PW'(trig_c_ff);
      s2_in.s02_s = PW'(s1_word_ff.dz_tangential)   * PW'(trig_s_ff);
      s2_in.s01_s = PW'(s1_word_ff.dz_radial)       * PW'(trig_s_ff);
      s2_in.s02_c = PW'(s1_word_ff.dz_tangential)   * PW'(trig_c_ff);
      s2_in.s10_c = PW'(s1_word_ff.dr_vertical)     * PW'(trig_c_ff);
      s2_in.s20_s = PW'(s1_word_ff.dt_vertical)     * PW'(trig_s_ff);
      s2_in.s10_s = PW'(s1_word_ff.dr_vertical)     * PW'(trig_s_ff);
      s2_in.s20_c = PW'(s1_word_ff.dt_vertical)     * PW'(trig_c_ff);
      s2_in.u1_hi = RHW'(s1_word_ff.disp_radial)     * inv_hi_ext;
      s2_in.u1_lo = RHW'(s1_word_ff.disp_radial)     * inv_lo_ext;
      s2_in.u2_hi = RHW'(s1_word_ff.disp_tangential) * inv_hi_ext;
      s2_in.u2_lo = RHW'(s1_word_ff.disp_tangential) * inv_lo_ext;
   end

   // ------------------------ stage 3: linear terms, connection terms, sums
   always_comb begin
      rad_u1 = (RW'(s2_ff.u1_hi) <<< INV_SPLIT) + RW'(s2_ff.u1_lo) + RAD_HALF;
      rad_u2 = (RW'(s2_ff.u2_hi) <<< INV_SPLIT) + RW'(s2_ff.u2_lo) + RAD_HALF;
      rad_q1 = rad_u1 >>> INV_WIDTH;
      rad_q2 = rad_u2 >>> INV_WIDTH;

      s3_in.lin.disp_z = s2_word_ff.disp_vertical;
      s3_in.lin.disp_x = lin_result(s2_ff.u1_c, s2_ff.u2_s, 1'b1);
      s3_in.lin.disp_y = lin_result(s2_ff.u1_s, s2_ff.u2_c, 1'b0);
      s3_in.lin.gz_z   = s2_word_ff.dz_vertical;
      s3_in.lin.gz_x   = lin_result(s2_ff.s01_c, s2_ff.s02_s, 1'b1);
      s3_in.lin.gz_y   = lin_result(s2_ff.s01_s, s2_ff.s02_c, 1'b0);
      s3_in.lin.gx_z   = lin_result(s2_ff.s10_c, s2_ff.s20_s, 1'b1);
      s3_in.lin.gy_z   = lin_result(s2_ff.s10_s, s2_ff.s20_c, 1'b0);

      // on axis the radial derivatives stand in for u/r
      s3_in.ur    = on_axis_ff ? s2_word_ff.dr_radial     : rad_q1[W-1:0];
      s3_in.ut    = on_axis_ff ? s2_word_ff.dr_tangential : rad_q2[W-1:0];
      s3_in.s11   = s2_word_ff.dr_radial;
      s3_in.s12   = s2_word_ff.dr_tangential;
      s3_in.s21   = s2_word_ff.dt_radial;
      s3_in.s22   = s2_word_ff.dt_tangential;
      s3_in.sum_a = XW'(s2_word_ff.dr_tangential) + XW'(s2_word_ff.dt_radial);
      s3_in.sum_b = XW'(s2_word_ff.dr_radial) - XW'(s2_word_ff.dt_tangential);
   end

   // -------------------------------------- stage 4: squared-trig products
   always_comb begin
      s4_in.lin    = s3_ff.lin;
      s4_in.s11_cc = QPW'(s3_ff.s11)   * QPW'(trig_cc_ff);
      s4_in.s22_ss = QPW'(s3_ff.s22)   * QPW'(trig_ss_ff);
      s4_in.a_sc   = QPW'(s3_ff.sum_a) * QPW'(trig_sc_ff);
      s4_in.ur_ss  = QPW'(s3_ff.ur)    * QPW'(trig_ss_ff);
      s4_in.ut_sc  = QPW'(s3_ff.ut)    * QPW'(trig_sc_ff);
      s4_in.s12_cc = QPW'(s3_ff.s12)   * QPW'(trig_cc_ff);
      s4_in.s21_ss = QPW'(s3_ff.s21)   * QPW'(trig_ss_ff);
      s4_in.b_sc   = QPW'(s3_ff.sum_b) * QPW'(trig_sc_ff);
      s4_in.ur_sc  = QPW'(s3_ff.ur)    * QPW'(trig_sc_ff);
      s4_in.ut_ss  = QPW'(s3_ff.ut)    * QPW'(trig_ss_ff);
      s4_in.s21_cc = QPW'(s3_ff.s21)   * QPW'(trig_cc_ff);
      s4_in.s12_ss = QPW'(s3_ff.s12)   * QPW'(trig_ss_ff);
      s4_in.ut_cc  = QPW'(s3_ff.ut)    * QPW'(trig_cc_ff);
      s4_in.s22_cc = QPW'(s3_ff.s22)   * QPW'(trig_cc_ff);
      s4_in.s11_ss = QPW'(s3_ff.s11)   * QPW'(trig_ss_ff);
      s4_in.ur_cc  = QPW'(s3_ff.ur)    * QPW'(trig_cc_ff);
   end

   // --------------------------------------------- stage 5: partial sums
   always_comb begin
      s5_in.lin  = s4_ff.lin;
      s5_in.xx_a = QSW'(s4_ff.s11_cc) + QSW'(s4_ff.s22_ss) - QSW'(s4_ff.a_sc);
      s5_in.xx_b = QSW'(s4_ff.ur_ss) + QSW'(s4_ff.ut_sc);
      s5_in.xy_a = QSW'(s4_ff.s12_cc) - QSW'(s4_ff.s21_ss) + QSW'(s4_ff.b_sc);
      s5_in.xy_b = QSW'(s4_ff.ut_ss) - QSW'(s4_ff.ur_sc);
      s5_in.yx_a = QSW'(s4_ff.s21_cc) - QSW'(s4_ff.s12_ss) + QSW'(s4_ff.b_sc);
      s5_in.yx_b = -QSW'(s4_ff.ur_sc) - QSW'(s4_ff.ut_cc);
      s5_in.yy_a = QSW'(s4_ff.s22_cc) + QSW'(s4_ff.s11_ss) + QSW'(s4_ff.a_sc);
      s5_in.yy_b = QSW'(s4_ff.ur_cc) - QSW'(s4_ff.ut_sc);
   end

   // ------------------------------------------ output: round and saturate
   always_comb begin
      rsp_data_in.out_disp_z = s5_ff.lin.disp_z;
      rsp_data_in.out_disp_x = s5_ff.lin.disp_x;
      rsp_data_in.out_disp_y = s5_ff.lin.disp_y;
      rsp_data_in.gz_of_z    = s5_ff.lin.gz_z;
      rsp_data_in.gz_of_x    = s5_ff.lin.gz_x;
      rsp_data_in.gz_of_y    = s5_ff.lin.gz_y;
      rsp_data_in.gx_of_z    = s5_ff.lin.gx_z;
      rsp_data_in.gx_of_x    = quad_result(s5_ff.xx_a, s5_ff.xx_b);
      rsp_data_in.gx_of_y    = quad_result(s5_ff.xy_a, s5_ff.xy_b);
      rsp_data_in.gy_of_z    = s5_ff.lin.gy_z;
      rsp_data_in.gy_of_x    = quad_result(s5_ff.yx_a, s5_ff.yx_b);
      rsp_data_in.gy_of_y    = quad_result(s5_ff.yy_a, s5_ff.yy_b);
   end

   always_ff @(posedge clock) begin
      if (s1_en) s1_word_ff <= req_data;
      if (s2_en) begin
         s2_word_ff <= s1_word_ff;
         s2_ff      <= s2_in;
      end
      if (s3_en) s3_ff <= s3_in;
      if (s4_en) s4_ff <= s4_in;
      if (s5_en) s5_ff <= s5_in;
      if (out_en) rsp_data_ff <= rsp_data_in;
   end

endmodule

[design/cgr_checker.sv]
// Port-level checks for the gradient rotation block, bound to its top level.
// Depends on cgr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cgr_checker
   import cgr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   // pipe is empty after reset
   `CGR_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

   // a stalled result word holds
   `CGR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // input backs up only behind a stalled, full output
   `CGR_ASSERT_IMP(a_stall_needs_backpressure, clock, reset, !rsp_valid || !rsp_stall, !req_stall)

endmodule

bind cyl_to_cart_gradient_rotation cgr_checker u_cgr_checker (.*);

[verif/cyl_to_cart_gradient_rotation_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for cyl_to_cart_gradient_rotation: random and directed samples with
// random backpressure, checked word by word against an in-bench rotation predictor.
// Depends on cgr_pkg and the block itself.

import cgr_pkg::*;

typedef logic signed [95:0] wide_type;

localparam int RSP_FIELDS = $bits(rsp_word_type) / DATA_WIDTH;
localparam int REQ_FIELDS = $bits(req_word_type) / DATA_WIDTH;

class rotation_scoreboard;
   logic [TRIG_WIDTH-1:0] cos_reg;
   logic [TRIG_WIDTH-1:0] sin_reg;
   logic [INV_WIDTH-1:0]  inv_reg;
   logic                  on_axis_reg;
   rsp_word_type          rotated_q[$];
   int                    mismatches;
   string field_names[RSP_FIELDS] = '{
      "out_disp_z", "out_disp_x", "out_disp_y", "gz_of_z", "gz_of_x", "gz_of_y",
      "gx_of_z", "gx_of_x", "gx_of_y", "gy_of_z", "gy_of_x", "gy_of_y"};

   function new();
      cos_reg     = TRIG_WIDTH'(1 << TRIG_FRAC);
      sin_reg     = '0;
      inv_reg     = '0;
      on_axis_reg = 1'b0;
      mismatches  = 0;
   endfunction

   function void apply_write(logic [CSR_INDEX_WIDTH-1:0] index,
                             logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         CSR_COS_ANGLE:  cos_reg     = data[TRIG_WIDTH-1:0];
         CSR_SIN_ANGLE:  sin_reg     = data[TRIG_WIDTH-1:0];
         CSR_INV_RADIUS: inv_reg     = data[INV_WIDTH-1:0];
         CSR_ON_AXIS:    on_axis_reg = data[0];
         default: ;
      endcase
   endfunction

   function wide_type round_shift(wide_type x, int n);
      return (x + (wide_type'(1) <<< (n - 1))) >>> n;
   endfunction

   function logic [DATA_WIDTH-1:0] saturate(wide_type x);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo = -(wide_type'(1) <<< (DATA_WIDTH - 1));
      if (x > hi) x = hi;
      if (x < lo) x = lo;
      return x[DATA_WIDTH-1:0];
   endfunction

   function wide_type clamp_trig(logic [TRIG_WIDTH-1:0] raw);
      wide_type t;
      wide_type one;
      one = wide_type'(1) <<< TRIG_FRAC;
      t = $signed(raw);
      if (t > one) t = one;
      if (t < -one) t = -one;
      return t;
   endfunction

   function rsp_word_type rotate_sample(req_word_type w);
      wide_type uz, urad, utan, dzv, dzr, dzt, drv, drr, drt, dtv, dtr, dtt;
      wide_type c, s, cc, ss, sc, inv_w, conn_r, conn_t;
      rsp_word_type r;
      uz   = w.disp_vertical;
      urad = w.disp_radial;
      utan = w.disp_tangential;
      dzv  = w.dz_vertical;
      dzr  = w.dz_radial;
      dzt  = w.dz_tangential;
      drv  = w.dr_vertical;
      drr  = w.dr_radial;
      drt  = w.dr_tangential;
      dtv  = w.dt_vertical;
      dtr  = w.dt_radial;
      dtt  = w.dt_tangential;
      c  = clamp_trig(cos_reg);
      s  = clamp_trig(sin_reg);
      cc = c * c;
      ss = s * s;
      sc = s * c;
      inv_w = '0;
      inv_w[INV_WIDTH-1:0] = inv_reg;
      // on axis the u/r connection terms fall back to the radial derivatives
      if (on_axis_reg) begin
         conn_r = drr;
         conn_t = drt;
      end else begin
         conn_r = round_shift(urad * inv_w, INV_WIDTH);
         conn_t = round_shift(utan * inv_w, INV_WIDTH);
      end
      r.out_disp_z = saturate(uz);
      r.out_disp_x = saturate(round_shift(urad * c - utan * s, TRIG_FRAC));
      r.out_disp_y = saturate(round_shift(urad * s + utan * c, TRIG_FRAC));
      r.gz_of_z    = saturate(dzv);
      r.gz_of_x    = saturate(round_shift(dzr * c - dzt * s, TRIG_FRAC));
      r.gz_of_y    = saturate(round_shift(dzr * s + dzt * c, TRIG_FRAC));
      r.gx_of_z    = saturate(round_shift(drv * c - dtv * s, TRIG_FRAC));
      r.gx_of_x    = saturate(round_shift(drr * cc + dtt * ss - (drt + dtr) * sc
                                          + conn_r * ss + conn_t * sc, 2 * TRIG_FRAC));
      r.gx_of_y    = saturate(round_shift(drt * cc - dtr * ss + (drr - dtt) * sc
                                          - conn_r * sc + conn_t * ss, 2 * TRIG_FRAC));
      r.gy_of_z    = saturate(round_shift(drv * s + dtv * c, TRIG_FRAC));
      r.gy_of_x    = saturate(round_shift(dtr * cc - drt * ss + (drr - dtt) * sc
                                          - conn_r * sc - conn_t * cc, 2 * TRIG_FRAC));
      r.gy_of_y    = saturate(round_shift(dtt * cc + drr * ss + (drt + dtr) * sc
                                          + conn_r * cc - conn_t * sc, 2 * TRIG_FRAC));
      return r;
   endfunction

   function void add_sample(req_word_type w);
      rotated_q.push_back(rotate_sample(w));
   endfunction

   function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endfunction

   function void check_word(rsp_word_type got);
      logic [$bits(rsp_word_type)-1:0] want_bits;
      logic [$bits(rsp_word_type)-1:0] got_bits;
      logic [DATA_WIDTH-1:0] want_f;
      logic [DATA_WIDTH-1:0] got_f;
      if (rotated_q.size() == 0) begin
         note_mismatch($sformatf("unexpected rsp word %h", got));
         return;
      end
      want_bits = rotated_q.pop_front();
      got_bits  = got;
      for (int k = 0; k < RSP_FIELDS; k++) begin
         want_f = want_bits[$bits(rsp_word_type)-1-DATA_WIDTH*k -: DATA_WIDTH];
         got_f  = got_bits[$bits(rsp_word_type)-1-DATA_WIDTH*k -: DATA_WIDTH];
         if (want_f !== got_f)
            note_mismatch($sformatf("mismatch %s: expected %h got %h",
                                    field_names[k], want_f, got_f));
      end
   endfunction

   function int pending();
      return rotated_q.size();
   endfunction
endclass

module cyl_to_cart_gradient_rotation_tb;

   typedef enum int {FILL_ZERO, FILL_MAX, FILL_MIN, FILL_ALT, FILL_ONE, FILL_NEG_ONE,
                     FILL_RANDOM} fill_kind_type;

   localparam logic [DATA_WIDTH-1:0] FIELD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] FIELD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(1 << TRIG_FRAC);
   localparam int SEGMENTS  = 12;
   localparam int SEG_ITEMS = 130;
   localparam int LONG_HOLD = 64;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_word_type               req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_word_type               rsp_data;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wr_data = '0;

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_req = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left = 0;

   rotation_scoreboard sb = new();

   cyl_to_cart_gradient_rotation dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.add_sample(req_data);
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_data);
      end
   end

   // receiver: random stall, or one long hold-off when asked
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_left  <= LONG_HOLD - 1;
         hold_taken <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   function automatic req_word_type fill_word(fill_kind_type kind);
      logic [$bits(req_word_type)-1:0] bits;
      logic [DATA_WIDTH-1:0] f;
      for (int k = 0; k < REQ_FIELDS; k++) begin
         case (kind)
            FILL_ZERO:    f = '0;
            FILL_MAX:     f = FIELD_MAX;
            FILL_MIN:     f = FIELD_MIN;
            FILL_ALT:     f = k[0] ? FIELD_MIN : FIELD_MAX;
            FILL_ONE:     f = DATA_WIDTH'(1);
            FILL_NEG_ONE: f = '1;
            default: begin
               case ($urandom_range(7, 0))
                  0:       f = FIELD_MAX;
                  1:       f = FIELD_MIN;
                  2, 3:    f = DATA_WIDTH'($urandom_range(32'h1ffff, 0) - 32'h10000);
                  default: f = DATA_WIDTH'($urandom);
               endcase
            end
         endcase
         bits[$bits(req_word_type)-1-DATA_WIDTH*k -: DATA_WIDTH] = f;
      end
      return req_word_type'(bits);
   endfunction

   function automatic logic [TRIG_WIDTH-1:0] pick_trig();
      case ($urandom_range(3, 0))
         0: return TRIG_WIDTH'($urandom);      // anything, clamp included
         1: begin
            case ($urandom_range(4, 0))
               0:       return TRIG_ONE;
               1:       return -TRIG_ONE;
               2:       return '0;
               3:       return {1'b0, {(TRIG_WIDTH-1){1'b1}}};
               default: return {1'b1, {(TRIG_WIDTH-1){1'b0}}};
            endcase
         end
         default: return TRIG_WIDTH'($urandom_range(2 * (1 << TRIG_FRAC), 0)
                                     - (1 << TRIG_FRAC));
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      sb.apply_write(index, data);
      @(negedge clock);
   endtask

   // junk in the unused upper bits, plus one write to a nonexistent index
   task automatic program_regs(input logic [TRIG_WIDTH-1:0] cos_val,
                               input logic [TRIG_WIDTH-1:0] sin_val,
                               input logic [INV_WIDTH-1:0] inv_val,
                               input logic axis_val);
      logic [CSR_DATA_WIDTH-1:0]  junk;
      logic [CSR_INDEX_WIDTH-1:0] spare;
      junk[CSR_DATA_WIDTH-1:16] = $urandom;
      junk[15:0] = 16'($urandom);
      spare = CSR_INDEX_WIDTH'($urandom_range(2 ** CSR_INDEX_WIDTH - 1, CSR_ON_AXIS + 1));
      csr_write(CSR_COS_ANGLE, {junk[CSR_DATA_WIDTH-1:TRIG_WIDTH], cos_val});
      csr_write(spare, junk);
      csr_write(CSR_SIN_ANGLE, {~junk[CSR_DATA_WIDTH-1:TRIG_WIDTH], sin_val});
      csr_write(CSR_INV_RADIUS, inv_val);
      csr_write(CSR_ON_AXIS, {junk[CSR_DATA_WIDTH-1:1], axis_val});
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [INV_WIDTH-1:0] inv_pick;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset register values: identity rotation, infinite radius
      send_word(fill_word(FILL_ZERO));
      send_word(fill_word(FILL_MAX));
      send_word(fill_word(FILL_MIN));
      send_word(fill_word(FILL_ALT));
      wait_drain();

      program_regs(-TRIG_ONE, TRIG_ONE, '1, 1'b0);
      send_word(fill_word(FILL_MAX));
      send_word(fill_word(FILL_MIN));
      send_word(fill_word(FILL_ALT));
      wait_drain();

      // cos = 0.5 puts +-1 inputs on the rounding midpoint
      program_regs(TRIG_WIDTH'(1 << (TRIG_FRAC - 1)), '0, INV_WIDTH'(1) << 30, 1'b1);
      send_word(fill_word(FILL_ONE));
      send_word(fill_word(FILL_NEG_ONE));
      send_word(fill_word(FILL_MAX));
      send_word(fill_word(FILL_MIN));
      wait_drain();

      // trig registers beyond +-1.0 get clamped
      program_regs({1'b0, {(TRIG_WIDTH-1){1'b1}}}, {1'b1, {(TRIG_WIDTH-1){1'b0}}},
                   '0, 1'b0);
      send_word(fill_word(FILL_MAX));
      send_word(fill_word(FILL_ALT));
      send_word(fill_word(FILL_RANDOM));
      wait_drain();

      program_regs(TRIG_WIDTH'(11585), -TRIG_ONE, {1'b0, {(INV_WIDTH-1){1'b1}}}, 1'b0);
      send_word(fill_word(FILL_NEG_ONE));
      send_word(fill_word(FILL_ONE));
      send_word(fill_word(FILL_RANDOM));
      send_word(fill_word(FILL_RANDOM));
      wait_drain();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 4)
            0: begin
               send_idle_pct  <= 19;
               recv_stall_pct <= 56;
            end
            1: begin
               send_idle_pct  <= 56;
               recv_stall_pct <= 19;
            end
            default: begin
               send_idle_pct  <= 0;
               recv_stall_pct <= 0;
            end
         endcase
         case ($urandom_range(3, 0))
            0: inv_pick = '0;
            1: inv_pick = '1;
            2: begin
               inv_pick[INV_WIDTH-1:32] = (INV_WIDTH-32)'($urandom);
               inv_pick[31:0] = $urandom;
            end
            default: inv_pick = INV_WIDTH'($urandom) << $urandom_range(16, 0);
         endcase
         program_regs(pick_trig(), pick_trig(), inv_pick, 1'($urandom_range(1, 0)));
         for (int n = 0; n < SEG_ITEMS; n++) begin
            // fill the pipe against a held-off receiver
            if (seg == SEGMENTS - 2 && n == 20) hold_req <= 1'b1;
            if (seg == 5 && n == SEG_ITEMS / 2) wait_drain();
            send_word(fill_word(FILL_RANDOM));
         end
         wait_drain();
      end

      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("cyl_to_cart_gradient_rotation_tb passed");
      end else begin
         $display("cyl_to_cart_gradient_rotation_tb failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("cyl_to_cart_gradient_rotation_tb failed");
      $finish;
   end

endmodule
